// ===== hw/rtl/sle_pkg.sv =====
package sle_pkg;

	localparam int VALUE_W  = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 4;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_RSVD    = 2'd3
	} status_t;

	// one request on the command channel
	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	// one result on the response channel
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
		logic                is_empty;
		logic                is_full;
	} res_t;

	// broadcast to every cell
	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

	// what a cell shows its neighbours and the top level
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] entry;
		logic                      gt;
		logic                      eq;
	} cell_view_t;

endpackage

// ===== hw/rtl/sle_cell.sv =====
module sle_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  sle_pkg::cell_ctl_t ctl,
	input  sle_pkg::cell_view_t lower,
	input  sle_pkg::cell_view_t upper,
	output sle_pkg::cell_view_t view
);
	import sle_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] entry_q;
	logic                      gt;
	logic                      ge;

	// an empty slot counts as larger than anything
	assign gt = !valid_q || ($signed(entry_q) > $signed(ctl.value));
	assign ge = valid_q && ($signed(entry_q) >= $signed(ctl.value));

	assign view.valid = valid_q;
	assign view.entry = entry_q;
	assign view.gt    = gt;
	assign view.eq    = valid_q && (entry_q == ctl.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (lower.gt) begin
				valid_q <= lower.valid;
			end else if (gt) begin
				valid_q <= 1'b1;
			end
		end else if (ctl.rem && ge) begin
			valid_q <= upper.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (lower.gt) begin
				entry_q <= lower.entry;
			end else if (gt) begin
				entry_q <= ctl.value;
			end
		end else if (ctl.rem && ge) begin
			entry_q <= upper.entry;
		end
	end

endmodule

// ===== hw/rtl/sorted_list_engine_core.sv =====
// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid, cmd_stall | sle_pkg::cmd_t (op, value)
// res     | out       | res_valid, res_stall | sle_pkg::res_t (status, count, flags)
//
// One request per cycle unless cmd_stall holds it off: every cell updates its own slot in the
// cycle the request is taken and the result appears in the output register
// on the next edge.
// arst_n clears the cell valid flags, the entry count and the result valid.
// cmd_stall rises only while a result sits unclaimed under res_stall.
module sorted_list_engine_core #(
	parameter int CAPACITY = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  sle_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output sle_pkg::res_t  res
);
	import sle_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	cell_view_t        views [CAPACITY];
	logic [CAPACITY-1:0] eq_vec;
	cell_ctl_t         ctl;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic              full;
	logic              found;
	logic              accept;
	logic [STATUS_W-1:0] status;
	logic              res_valid_q;
	res_t              res_q;

	// the output register frees itself when taken, so a new request can
	// land in the same cycle
	assign cmd_stall = res_valid_q && res_stall;
	assign accept    = cmd_valid && !cmd_stall;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign found = |eq_vec;

	assign ctl.value = cmd.value;
	assign ctl.ins   = accept && (cmd.op == OP_INSERT) && !full;
	assign ctl.rem   = accept && (cmd.op == OP_REMOVE) && found;

	// Row of cells: cell 0 sees a lower neighbour that is never larger,
	// the top cell sees an empty slot above it.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_view_t lower;
		cell_view_t upper;

		if (i == 0) begin : g_bottom
			assign lower = '0;
		end else begin : g_lower
			assign lower = views[i-1];
		end

		if (i == CAPACITY - 1) begin : g_top
			assign upper = '0;
		end else begin : g_upper
			assign upper = views[i+1];
		end

		sle_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.lower (lower),
			.upper (upper),
			.view  (views[i])
		);

		assign eq_vec[i] = views[i].eq;
	end

	always_comb begin
		status     = ST_DONE;
		count_next = count_q;
		unique case (cmd.op)
			OP_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (found) begin
					count_next = count_q - 1'b1;
				end else begin
					status = ST_MISSING;
				end
			end
			OP_LOOKUP: begin
				if (!found) begin
					status = ST_MISSING;
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status      <= status;
			res_q.entry_count <= COUNT_W'(count_next);
			res_q.is_empty    <= (count_next == '0);
			res_q.is_full     <= (count_next == CNT_W'(CAPACITY));
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hw/rtl/sle_checker.sv =====
module sle_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input sle_pkg::cmd_t cmd,
	input logic          res_valid,
	input logic          res_stall,
	input sle_pkg::res_t res
);
	import sle_pkg::*;

	// a held result keeps its value
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// every taken request yields a result on the next edge
	a_res_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("request taken without result");

	// no result out of nowhere
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_valid && !cmd_stall))
		else $error("result without request");

	// a refused insert reports a full list
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.status == ST_FULL) |-> res.is_full && !res.is_empty)
		else $error("full status on a list that is not full");

endmodule

bind sorted_list_engine_core sle_checker u_sle_checker (.*);
